### sv/lwwb_pkg.sv
package lwwb_pkg;

  // Field widths fixed by the item formats.
  localparam int PRICE_W    = 16;
  localparam int LEN_W      = 11;
  localparam int BUDGET_W   = 32;
  localparam int SUM_W      = 33;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register word index, taken from paddr[2].
  localparam logic REG_BUDGET = 1'b0;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] best_length;
    logic             window_capped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT_RD,
    ST_EVICT,
    ST_APPEND,
    ST_TEST,
    ST_DROP
  } state_t;

  // Commands to the shared running-sum unit.
  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } sum_cmd_t;

endpackage

### sv/longest_window_within_budget.sv
// Longest contiguous run of prices whose sum stays within a budget.
//
// Input channel (in_valid/in_ready/in_data) takes one price per transaction;
// a sequence ends with a transaction whose last bit is set. Output channel
// (out_valid/out_ready/out_data) carries one result per sequence: the best
// window length and a flag telling whether a window outgrew the ring store.
// The budget register sits at APB byte address 0; the user must write it
// only while the block is idle, as the block itself does not enforce this.
//
// Steps: an item goes through accept, append and test. Every price dropped
// from the window adds a drop and a fresh test, and when the store is full
// the oldest price is first evicted through an evict-read and an evict
// step. Each drop needs a registered read of the ring memory followed by
// one pass through the shared adder; each price is dropped at most once.
// The result is registered and shows in the cycle after the final test.
//
// Reset clears the sequence state, the budget and the output valid flag; the
// ring memory is not cleared, since only entries of the current sequence are
// read. While a result waits for out_ready, the block keeps accepting prices;
// it only holds at the end of the next sequence until the result is taken.
module longest_window_within_budget
  import lwwb_pkg::*;
#(
  parameter int WINDOW_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  state_t              state;
  state_t              state_next;
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic [CW-1:0]       best;
  logic                capped;
  logic [PRICE_W-1:0]  price_q;
  logic                last_q;
  logic [PRICE_W-1:0]  rdata;
  logic [BUDGET_W-1:0] budget;
  logic [PRICE_W-1:0]  mem [WINDOW_DEPTH];

  logic                over;
  logic                full;
  logic                out_free;
  logic [CW:0]         tail_wide;
  logic [AW-1:0]       tail;
  logic [CW-1:0]       best_new;

  // Sequencer control.
  sum_cmd_t sum_cmd;
  logic     mem_we;
  logic     head_inc;
  logic     count_inc;
  logic     count_dec;
  logic     set_capped;
  logic     upd_best;
  logic     load_out;
  logic     clear_seq;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUDGET) ? APB_DATA_W'(budget) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_BUDGET) begin
      budget <= pwdata[BUDGET_W-1:0];
    end
  end

  // Window bookkeeping values.
  always_comb begin
    full      = count == CW'(WINDOW_DEPTH);
    out_free  = !out_valid || out_ready;
    tail_wide = (CW+1)'(head) + (CW+1)'(count);
    if (tail_wide >= (CW+1)'(WINDOW_DEPTH)) begin
      tail_wide = tail_wide - (CW+1)'(WINDOW_DEPTH);
    end
    tail     = tail_wide[AW-1:0];
    best_new = (count > best) ? count : best;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = full ? ST_EVICT_RD : ST_APPEND;
        end
      end
      ST_EVICT_RD: state_next = ST_EVICT;
      ST_EVICT:    state_next = ST_APPEND;
      ST_APPEND:   state_next = ST_TEST;
      ST_TEST: begin
        if (count != '0 && over) begin
          state_next = ST_DROP;
        end else if (!last_q || out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DROP:     state_next = ST_TEST;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    sum_cmd    = '0;
    mem_we     = 1'b0;
    head_inc   = 1'b0;
    count_inc  = 1'b0;
    count_dec  = 1'b0;
    set_capped = 1'b0;
    upd_best   = 1'b0;
    load_out   = 1'b0;
    clear_seq  = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_EVICT: begin
        sum_cmd.sub = 1'b1;
        head_inc    = 1'b1;
        count_dec   = 1'b1;
        set_capped  = 1'b1;
      end
      ST_APPEND: begin
        sum_cmd.add = 1'b1;
        mem_we      = 1'b1;
        count_inc   = 1'b1;
      end
      ST_TEST: begin
        if (!(count != '0 && over)) begin
          if (!last_q) begin
            upd_best = 1'b1;
          end else if (out_free) begin
            load_out      = 1'b1;
            clear_seq     = 1'b1;
            sum_cmd.clear = 1'b1;
          end
        end
      end
      ST_DROP: begin
        sum_cmd.sub = 1'b1;
        head_inc    = 1'b1;
        count_dec   = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Ring store: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= price_q;
    end
    rdata <= mem[head];
  end

  // Captured input item.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      price_q <= in_data.price;
      last_q  <= in_data.last;
    end
  end

  // Sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      head   <= '0;
      count  <= '0;
      best   <= '0;
      capped <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_seq) begin
        head   <= '0;
        count  <= '0;
        best   <= '0;
        capped <= 1'b0;
      end else begin
        if (head_inc) begin
          head <= (head == AW'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
        end
        if (count_inc) begin
          count <= count + 1'b1;
        end else if (count_dec) begin
          count <= count - 1'b1;
        end
        if (set_capped) begin
          capped <= 1'b1;
        end
        if (upd_best) begin
          best <= best_new;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.best_length   <= LEN_W'(best_new);
      out_data.window_capped <= capped;
    end
  end

  lwwb_sum_unit u_sum (
    .clk     (clk),
    .rst     (rst),
    .cmd     (sum_cmd),
    .operand ((state == ST_APPEND) ? price_q : rdata),
    .budget  (budget),
    .over    (over)
  );

endmodule

### sv/lwwb_sum_unit.sv
module lwwb_sum_unit
  import lwwb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  sum_cmd_t            cmd,
  input  logic [PRICE_W-1:0]  operand,
  input  logic [BUDGET_W-1:0] budget,
  output logic                over
);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] addend;

  // One adder serves append, drop and evict; a drop or evict adds the two's complement.
  always_comb begin
    addend   = cmd.sub ? ~SUM_W'(operand) : SUM_W'(operand);
    sum_next = sum + addend + SUM_W'(cmd.sub);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum <= '0;
    end else if (cmd.add || cmd.sub) begin
      sum <= sum_next;
    end
  end

  // The window breaks the budget when its sum is strictly above it.
  assign over = sum > SUM_W'(budget);

endmodule

### sv/lwwb_checker.sv
module lwwb_checker
  import lwwb_pkg::*;
#(
  parameter int WINDOW_DEPTH = 1024
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // The block works on one price at a time, so it drops ready after a transaction.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a price is still in work");

  // A reported length never exceeds the ring store.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.best_length) <= WINDOW_DEPTH)
    else $error("best length beyond store depth");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind longest_window_within_budget lwwb_checker #(
  .WINDOW_DEPTH(WINDOW_DEPTH)
) u_lwwb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
